// ===== rtl/pulse_flow_meter_ema_macros.svh =====
// Assertion shorthands for the checker of the flow meter.
`ifndef PULSE_FLOW_METER_EMA_MACROS_SVH
`define PULSE_FLOW_METER_EMA_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PFM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PFM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pfm_ema_pkg.sv =====
package pfm_ema_pkg;

    // Field widths.
    localparam int VAL_W      = 32;
    localparam int K_W        = 16;
    localparam int TAU_W      = 27;
    localparam int AREA_W     = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 27;

    // Serial units produce one bit per cycle over a 32-bit word.
    localparam int ITER_W = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_SCALE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_PERIOD    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CROSS_SECTION = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [K_W-1:0]    PULSE_SCALE_RESET   = 16'd1920;
    localparam logic [TAU_W-1:0]  AVG_PERIOD_RESET    = 27'd1000000;
    localparam logic [AREA_W-1:0] CROSS_SECTION_RESET = 20'd1000;

    // Item operation codes.
    localparam logic OP_PULSE  = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // Scale factors: microseconds per second, and 1e6 mm^3 per litre over 60 s per minute,
    // kept as 50000 / 3 so that speed = avg * 50000 / (3 * area).
    localparam logic [VAL_W-1:0] MICRO_SCALE = 32'd1000000;
    localparam logic [VAL_W-1:0] SPEED_SCALE = 32'd50000;
    localparam logic [VAL_W-1:0] SAT_VALUE   = 32'hFFFF_FFFF;

endpackage

// ===== rtl/pfm_in_if.sv =====
interface pfm_in_if;

    logic                              valid;
    logic                              ready;
    logic                              op;
    logic [pfm_ema_pkg::VAL_W-1:0]     elapsed_us;

    modport source (output valid, output op, output elapsed_us, input ready);
    modport sink   (input valid, input op, input elapsed_us, output ready);

endinterface

// ===== rtl/pfm_out_if.sv =====
interface pfm_out_if;

    logic                              valid;
    logic                              ready;
    logic [pfm_ema_pkg::VAL_W-1:0]     frequency_hz;
    logic [pfm_ema_pkg::VAL_W-1:0]     inst_flow;
    logic [pfm_ema_pkg::VAL_W-1:0]     avg_flow;
    logic [pfm_ema_pkg::VAL_W-1:0]     speed_mm_s;
    logic [pfm_ema_pkg::VAL_W-1:0]     pulses_in_window;

    modport source (
        output valid, output frequency_hz, output inst_flow, output avg_flow,
        output speed_mm_s, output pulses_in_window, input ready
    );
    modport sink (
        input valid, input frequency_hz, input inst_flow, input avg_flow,
        input speed_mm_s, input pulses_in_window, output ready
    );

endinterface

// ===== rtl/pulse_flow_meter_ema.sv =====
// Pulse flow meter with exponentially smoothed flow.
// Input channel (in_ch): each item is either a rising sensor edge (op = pulse), which only
// advances the pulse counter and gives no result, or a periodic update (op = update) carrying
// the microseconds since the previous update. Each update gives exactly one result item on
// out_ch with frequency, instantaneous flow, smoothed flow, duct speed and the pulse count.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data), to be written by the
// user while idle; the block itself does not enforce this. Every division runs through one
// shared restoring divider and every product through one shift-and-add multiplier, each with
// one operand load, then one bit a cycle over 32 bits; up to seven such passes run one after
// another for an update (five with smoothing off, two when no time has elapsed). The input
// is closed until the result is registered, so a new update is taken only once the previous
// one is through.
// Pulse items are taken every cycle while no update is in progress.
// The result sits in an output register, so a new item is accepted while the previous result
// waits; if the receiver still stalls when the next result is ready, the block holds it and
// accepts nothing until the output register frees.
// Reset clears the counter, the held frequency, flow and average, and loads the configuration
// registers with their defaults; no result is pending after reset.
module pulse_flow_meter_ema #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    pfm_in_if.sink                               in_ch,
    pfm_out_if.source                            out_ch,
    input  logic                                 cfg_wr_en,
    input  logic [pfm_ema_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pfm_ema_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // The widest dividend is pulses * 1e6 (52 bits) scaled by the fraction bits, or a
    // 64-bit product in the averaging step.
    localparam int DVD_W  = (52 + FRACTION_BITS > 64) ? 52 + FRACTION_BITS : 64;
    // The part of the dividend above the 32 quotient bits, with one guard bit.
    localparam int CMP_W  = DVD_W - 31;
    localparam int VAL_W  = pfm_ema_pkg::VAL_W;
    localparam int DVS_W  = VAL_W + 1;
    localparam int ITER_W = pfm_ema_pkg::ITER_W;
    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(VAL_W - 1);

    // Sequencer states.
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_FREQ_MUL = 4'd1;
    localparam logic [3:0] ST_FREQ_DIV = 4'd2;
    localparam logic [3:0] ST_FLOW_DIV = 4'd3;
    localparam logic [3:0] ST_AVG_MUL  = 4'd4;
    localparam logic [3:0] ST_AVG_DIV  = 4'd5;
    localparam logic [3:0] ST_SPD_MUL  = 4'd6;
    localparam logic [3:0] ST_SPD_DIV  = 4'd7;
    localparam logic [3:0] ST_DONE     = 4'd8;

    // Control and state registers.
    logic [3:0]                         state_reg, state_next;
    logic [ITER_W-1:0]                  cnt_reg, cnt_next;
    logic                               ld_reg, ld_next;
    logic                               out_valid_reg, out_valid_next;
    logic [pfm_ema_pkg::K_W-1:0]        k_reg, k_next;
    logic [pfm_ema_pkg::TAU_W-1:0]      tau_reg, tau_next;
    logic [pfm_ema_pkg::AREA_W-1:0]     area_reg, area_next;
    logic [VAL_W-1:0]                   count_reg, count_next;
    logic [VAL_W-1:0]                   freq_reg, freq_next;
    logic [VAL_W-1:0]                   flow_reg, flow_next;
    logic [VAL_W-1:0]                   avg_reg, avg_next;

    // Datapath registers.
    logic [VAL_W-1:0]                   pulses_reg, pulses_next;
    logic [VAL_W-1:0]                   elapsed_reg, elapsed_next;
    logic [VAL_W-1:0]                   speed_reg, speed_next;
    logic                               up_reg, up_next;
    logic [2*VAL_W-1:0]                 mp_reg, mp_next;
    logic [VAL_W-1:0]                   ma_reg, ma_next;
    logic [DVS_W+VAL_W-1:0]             dr_reg, dr_next;
    logic [DVS_W-1:0]                   dv_reg, dv_next;
    logic                               dovf_reg, dovf_next;
    logic [VAL_W-1:0]                   o_freq_reg, o_freq_next;
    logic [VAL_W-1:0]                   o_flow_reg, o_flow_next;
    logic [VAL_W-1:0]                   o_avg_reg, o_avg_next;
    logic [VAL_W-1:0]                   o_speed_reg, o_speed_next;
    logic [VAL_W-1:0]                   o_pulses_reg, o_pulses_next;

    // Serial multiplier: one multiplier bit a cycle, the partial sum shifts down.
    logic [VAL_W:0]                     mul_sum;
    logic [2*VAL_W-1:0]                 mul_step;

    // Restoring divider: one quotient bit a cycle, quotient bits enter at the bottom.
    logic [DVS_W:0]                     div_trial;
    logic [DVS_W:0]                     div_diff;
    logic                               div_ge;
    logic [DVS_W+VAL_W-1:0]             div_step;
    logic [VAL_W-1:0]                   div_quot;

    // Operand selection for loading the divider.
    logic [DVD_W-1:0]                   div_dvd;
    logic [DVS_W-1:0]                   div_dvs;
    logic [CMP_W-1:0]                   div_hi;
    logic                               div_ovf;
    logic [DVS_W-1:0]                   area_x3;

    logic                               in_accept;
    logic                               flow_ge_avg;
    logic [VAL_W-1:0]                   flow_avg_diff;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_accept   = in_ch.valid && in_ch.ready;

    assign mul_sum  = {1'b0, mp_reg[2*VAL_W-1:VAL_W]} + (mp_reg[0] ? {1'b0, ma_reg} : '0);
    assign mul_step = {mul_sum, mp_reg[VAL_W-1:1]};

    assign div_trial = {dr_reg[DVS_W+VAL_W-1:VAL_W], dr_reg[VAL_W-1]};
    assign div_diff  = div_trial - {1'b0, dv_reg};
    assign div_ge    = (div_trial >= {1'b0, dv_reg});
    assign div_step  = {div_ge ? div_diff[DVS_W-1:0] : div_trial[DVS_W-1:0],
                        dr_reg[VAL_W-2:0], div_ge};
    // An oversized quotient or a zero divisor is flagged at load and saturates.
    assign div_quot  = dovf_reg ? pfm_ema_pkg::SAT_VALUE : div_step[VAL_W-1:0];

    assign area_x3 = (DVS_W'(area_reg) << 1) + DVS_W'(area_reg);

    always_comb
    begin
        case (state_reg)
            ST_FREQ_DIV:
            begin
                div_dvd = DVD_W'(mp_reg) << FRACTION_BITS;
                div_dvs = DVS_W'(elapsed_reg);
            end
            ST_FLOW_DIV:
            begin
                div_dvd = DVD_W'({freq_reg, 8'd0});
                div_dvs = DVS_W'(k_reg);
            end
            ST_AVG_DIV:
            begin
                div_dvd = DVD_W'(mp_reg);
                div_dvs = DVS_W'(tau_reg) + DVS_W'(elapsed_reg);
            end
            default:
            begin
                div_dvd = DVD_W'(mp_reg);
                div_dvs = area_x3;
            end
        endcase
    end

    assign div_hi  = {1'b0, div_dvd[DVD_W-1:VAL_W]};
    assign div_ovf = (div_hi >= CMP_W'(div_dvs));

    assign flow_ge_avg   = (flow_reg >= avg_reg);
    assign flow_avg_diff = flow_ge_avg ? (flow_reg - avg_reg) : (avg_reg - flow_reg);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ld_next        = ld_reg;
        out_valid_next = out_valid_reg;
        k_next         = k_reg;
        tau_next       = tau_reg;
        area_next      = area_reg;
        count_next     = count_reg;
        freq_next      = freq_reg;
        flow_next      = flow_reg;
        avg_next       = avg_reg;
        pulses_next    = pulses_reg;
        elapsed_next   = elapsed_reg;
        speed_next     = speed_reg;
        up_next        = up_reg;
        mp_next        = mp_reg;
        ma_next        = ma_reg;
        dr_next        = dr_reg;
        dv_next        = dv_reg;
        dovf_next      = dovf_reg;
        o_freq_next    = o_freq_reg;
        o_flow_next    = o_flow_reg;
        o_avg_next     = o_avg_reg;
        o_speed_next   = o_speed_reg;
        o_pulses_next  = o_pulses_reg;

        if (cfg_wr_en)
        begin
            case (cfg_index)
                pfm_ema_pkg::CFG_PULSE_SCALE:   k_next    = cfg_data[pfm_ema_pkg::K_W-1:0];
                pfm_ema_pkg::CFG_AVG_PERIOD:    tau_next  = cfg_data[pfm_ema_pkg::TAU_W-1:0];
                pfm_ema_pkg::CFG_CROSS_SECTION: area_next = cfg_data[pfm_ema_pkg::AREA_W-1:0];
                default:                        ;
            endcase
        end

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_ch.op == pfm_ema_pkg::OP_PULSE)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        pulses_next  = count_reg;
                        count_next   = '0;
                        elapsed_next = in_ch.elapsed_us;
                        ld_next      = 1'b1;
                        // With no elapsed time the held values stand; only speed is redone.
                        state_next   = (in_ch.elapsed_us == '0) ? ST_SPD_MUL : ST_FREQ_MUL;
                    end
                end
            end

            ST_FREQ_MUL, ST_AVG_MUL, ST_SPD_MUL:
            begin
                if (ld_reg)
                begin
                    cnt_next = '0;
                    ld_next  = 1'b0;
                    if (state_reg == ST_FREQ_MUL)
                    begin
                        ma_next = pulses_reg;
                        mp_next = {{VAL_W{1'b0}}, pfm_ema_pkg::MICRO_SCALE};
                    end
                    else if (state_reg == ST_AVG_MUL)
                    begin
                        ma_next = flow_avg_diff;
                        mp_next = {{VAL_W{1'b0}}, elapsed_reg};
                        up_next = flow_ge_avg;
                        if (tau_reg == '0)
                        begin
                            // No smoothing: the average follows the flow directly.
                            avg_next   = flow_reg;
                            ld_next    = 1'b1;
                            state_next = ST_SPD_MUL;
                        end
                    end
                    else
                    begin
                        ma_next = avg_reg;
                        mp_next = {{VAL_W{1'b0}}, pfm_ema_pkg::SPEED_SCALE};
                    end
                end
                else
                begin
                    mp_next  = mul_step;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == LAST_ITER)
                    begin
                        ld_next    = 1'b1;
                        state_next = state_reg + 1'b1;
                    end
                end
            end

            ST_FREQ_DIV, ST_FLOW_DIV, ST_AVG_DIV, ST_SPD_DIV:
            begin
                if (ld_reg)
                begin
                    cnt_next  = '0;
                    ld_next   = 1'b0;
                    dr_next   = {div_hi[DVS_W-1:0], div_dvd[VAL_W-1:0]};
                    dv_next   = div_dvs;
                    dovf_next = div_ovf;
                end
                else
                begin
                    dr_next  = div_step;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == LAST_ITER)
                    begin
                        ld_next    = 1'b1;
                        state_next = state_reg + 1'b1;
                        case (state_reg)
                            ST_FREQ_DIV: freq_next  = div_quot;
                            ST_FLOW_DIV: flow_next  = div_quot;
                            ST_AVG_DIV:
                            begin
                                // The step never exceeds the difference, so no overflow.
                                avg_next = up_reg ? (avg_reg + div_step[VAL_W-1:0])
                                                  : (avg_reg - div_step[VAL_W-1:0]);
                            end
                            default:     speed_next = div_quot;
                        endcase
                    end
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    o_freq_next    = freq_reg;
                    o_flow_next    = flow_reg;
                    o_avg_next     = avg_reg;
                    o_speed_next   = speed_reg;
                    o_pulses_next  = pulses_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ld_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            k_reg         <= pfm_ema_pkg::PULSE_SCALE_RESET;
            tau_reg       <= pfm_ema_pkg::AVG_PERIOD_RESET;
            area_reg      <= pfm_ema_pkg::CROSS_SECTION_RESET;
            count_reg     <= '0;
            freq_reg      <= '0;
            flow_reg      <= '0;
            avg_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ld_reg        <= ld_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            tau_reg       <= tau_next;
            area_reg      <= area_next;
            count_reg     <= count_next;
            freq_reg      <= freq_next;
            flow_reg      <= flow_next;
            avg_reg       <= avg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pulses_reg   <= pulses_next;
        elapsed_reg  <= elapsed_next;
        speed_reg    <= speed_next;
        up_reg       <= up_next;
        mp_reg       <= mp_next;
        ma_reg       <= ma_next;
        dr_reg       <= dr_next;
        dv_reg       <= dv_next;
        dovf_reg     <= dovf_next;
        o_freq_reg   <= o_freq_next;
        o_flow_reg   <= o_flow_next;
        o_avg_reg    <= o_avg_next;
        o_speed_reg  <= o_speed_next;
        o_pulses_reg <= o_pulses_next;
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.frequency_hz     = o_freq_reg;
    assign out_ch.inst_flow        = o_flow_reg;
    assign out_ch.avg_flow         = o_avg_reg;
    assign out_ch.speed_mm_s       = o_speed_reg;
    assign out_ch.pulses_in_window = o_pulses_reg;

endmodule

// ===== rtl/pfm_ema_checker.sv =====
`include "pulse_flow_meter_ema_macros.svh"

module pfm_ema_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              in_op,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [pfm_ema_pkg::VAL_W-1:0]     out_frequency_hz,
    input logic [pfm_ema_pkg::VAL_W-1:0]     out_inst_flow,
    input logic [pfm_ema_pkg::VAL_W-1:0]     out_avg_flow,
    input logic [pfm_ema_pkg::VAL_W-1:0]     out_speed_mm_s,
    input logic [pfm_ema_pkg::VAL_W-1:0]     out_pulses_in_window
);

    logic                                    out_stall;
    logic [5*pfm_ema_pkg::VAL_W-1:0]         out_data;
    logic                                    take_update;
    logic                                    take_pulse;

    assign out_stall   = out_valid && !out_ready;
    assign out_data    = {out_frequency_hz, out_inst_flow, out_avg_flow, out_speed_mm_s,
                          out_pulses_in_window};
    assign take_update = in_valid && in_ready && (in_op == pfm_ema_pkg::OP_UPDATE);
    assign take_pulse  = in_valid && in_ready && (in_op == pfm_ema_pkg::OP_PULSE);

    // A stalled result stays offered.
    `PFM_ASSERT_NEXT(a_out_valid_held, clk, rst_n, out_stall, out_valid, "result withdrawn")

    // A stalled result keeps its value.
    `PFM_ASSERT_NEXT(a_out_data_held, clk, rst_n, out_stall, $stable(out_data), "result changed")

    // An update occupies the block, so nothing is taken in the following cycle.
    `PFM_ASSERT_NEXT(a_update_busy, clk, rst_n, take_update, !in_ready, "taken while busy")

    // A pulse item is counted without stalling the input; the block stays open for the next one.
    `PFM_ASSERT_NEXT(a_pulse_no_stall, clk, rst_n, take_pulse, in_ready, "pulse stalled input")

    // A new result appears only as the block goes back to waiting for items.
    `PFM_ASSERT_SAME(a_result_then_ready, clk, rst_n, $rose(out_valid), in_ready, "early result")

endmodule

bind pulse_flow_meter_ema pfm_ema_checker u_pfm_ema_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_ch.valid),
    .in_ready             (in_ch.ready),
    .in_op                (in_ch.op),
    .out_valid            (out_ch.valid),
    .out_ready            (out_ch.ready),
    .out_frequency_hz     (out_ch.frequency_hz),
    .out_inst_flow        (out_ch.inst_flow),
    .out_avg_flow         (out_ch.avg_flow),
    .out_speed_mm_s       (out_ch.speed_mm_s),
    .out_pulses_in_window (out_ch.pulses_in_window)
);
